@@ src/stsg_pkg.sv @@
// Shared types, register codes and sine table arithmetic for the sine tone sample generator.
// No dependencies; the files that use it refer to it by scoped names.
package stsg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TUNING_WORD     = 3'd0;
  localparam logic [2:0] REG_SAMPLE_WIDTH    = 3'd1;
  localparam logic [2:0] REG_CONTAINER_BYTES = 3'd2;
  localparam logic [2:0] REG_BIG_ENDIAN      = 3'd3;
  localparam logic [2:0] REG_UNSIGNED_FORMAT = 3'd4;

  // Sample width codes
  localparam logic [1:0] SW_8BIT  = 2'd0;
  localparam logic [1:0] SW_16BIT = 2'd1;
  localparam logic [1:0] SW_24BIT = 2'd2;
  localparam logic [1:0] SW_32BIT = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] TUNING_WORD_RST     = 32'd10711;
  localparam logic [1:0]  SAMPLE_WIDTH_RST    = SW_24BIT;
  localparam logic [2:0]  CONTAINER_BYTES_RST = 3'd4;

  // Sine magnitude is Q0.23
  localparam int unsigned MAG_W    = 23;
  localparam logic [22:0] SINE_MAX = 23'h7FFFFF;
  localparam logic [63:0] Q30_ONE  = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic phase_restart;
    logic end_of_burst;
  } frame_req_t;

  typedef struct packed {
    logic [31:0] sample_bytes;
    logic [2:0]  channel_index;
    logic        last_of_frame;
    logic        burst_done;
  } sample_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [31:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] tuning_word;
    logic [1:0]  sample_width_code;
    logic [2:0]  container_bytes;
    logic        big_endian_order;
    logic        unsigned_format;
  } cfg_t;

  // Queue entry: resolved phase of one frame plus its burst marker
  typedef struct packed {
    logic [31:0] phase;
    logic        end_of_burst;
  } frame_t;

  // Quarter-wave entry n for a table of 2^abits steps; evaluated at elaboration only
  function automatic logic [22:0] sine_entry(int unsigned n, int unsigned abits);
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    x  = 64'(n) << (30 - abits);
    a  = (x * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    t  = Q30_ONE;
    // Horner steps of the Taylor series, innermost term first
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    s  = (s + 64'd64) >> 7;
    if (s > 64'(SINE_MAX)) begin
      s = 64'(SINE_MAX);
    end
    return s[22:0];
  endfunction

endpackage

@@ src/stsg_stream_if.sv @@
// Valid/ready stream interface used for every channel of the sine tone sample generator.
// Payload type is a parameter; depends on nothing else.
interface stsg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/sine_tone_sample_generator.sv @@
// Top level of the sine tone sample generator: front end, frame queue and back end.
// Depends on stsg_pkg, stsg_stream_if, stsg_front, stsg_queue, stsg_back and stsg_ram.
//
// Phase-accumulator sine source. After reset the quarter-wave table is loaded, and during
// the load no frame request is taken (register writes are).
// Each accepted frame request produces CHANNELS samples, one per cycle from the output
// register while the output is ready; the output register holds each frame until its last
// channel is taken, so with a single channel one frame per cycle can be accepted. From
// the queue a frame passes three register stages, table read, scaling multiply and
// formatting, before its first sample leaves. A four-entry queue between the front and
// back lets requests keep flowing while the output is stalled. Write configuration only
// while the block is idle.
module sine_tone_sample_generator #(
  parameter int unsigned CHANNELS        = 1,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stsg_stream_if.sink   cfg_i,
  stsg_stream_if.sink   frame_req_i,
  stsg_stream_if.source sample_o
);

  localparam int unsigned QUEUE_DEPTH = 4;

  stsg_pkg::cfg_t cfg;
  logic           fill_done;

  stsg_stream_if #(.payload_t(stsg_pkg::frame_t)) front_if ();
  stsg_stream_if #(.payload_t(stsg_pkg::frame_t)) back_if ();

  stsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .frame_req_i (frame_req_i),
    .frame_o     (front_if),
    .fill_done_i (fill_done),
    .cfg_o       (cfg)
  );

  stsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_if),
    .out_o  (back_if)
  );

  stsg_back #(
    .CHANNELS        (CHANNELS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (back_if),
    .sample_o    (sample_o),
    .cfg_i       (cfg),
    .fill_done_o (fill_done)
  );

endmodule

@@ src/stsg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; no package use.
module stsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/stsg_front.sv @@
// Front end: configuration registers, phase accumulator and frame request intake.
// Depends on stsg_pkg and stsg_stream_if.
module stsg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  stsg_stream_if.sink   cfg_i,
  stsg_stream_if.sink   frame_req_i,
  stsg_stream_if.source frame_o,
  input  logic          fill_done_i,
  output stsg_pkg::cfg_t cfg_o
);

  stsg_pkg::cfg_t cfg_q, cfg_d;
  logic [31:0]    acc_q, acc_d;
  logic [31:0]    phase;
  logic           accept;

  // Take register writes at any time
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        stsg_pkg::REG_TUNING_WORD:     cfg_d.tuning_word       = cfg_i.data.wdata;
        stsg_pkg::REG_SAMPLE_WIDTH:    cfg_d.sample_width_code = cfg_i.data.wdata[1:0];
        stsg_pkg::REG_CONTAINER_BYTES: cfg_d.container_bytes   = cfg_i.data.wdata[2:0];
        stsg_pkg::REG_BIG_ENDIAN:      cfg_d.big_endian_order  = cfg_i.data.wdata[0];
        stsg_pkg::REG_UNSIGNED_FORMAT: cfg_d.unsigned_format   = cfg_i.data.wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Pass requests to the queue once the sine table is loaded
  assign frame_req_i.ready = frame_o.ready & fill_done_i;
  assign frame_o.valid     = frame_req_i.valid & fill_done_i;
  assign accept            = frame_req_i.valid & frame_req_i.ready;

  // Resolve restart, then advance the phase with natural wrap
  assign phase = frame_req_i.data.phase_restart ? 32'd0 : acc_q;
  assign acc_d = accept ? (phase + cfg_q.tuning_word) : acc_q;

  assign frame_o.data.phase        = phase;
  assign frame_o.data.end_of_burst = frame_req_i.data.end_of_burst;
  assign cfg_o                     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tuning_word       <= stsg_pkg::TUNING_WORD_RST;
      cfg_q.sample_width_code <= stsg_pkg::SAMPLE_WIDTH_RST;
      cfg_q.container_bytes   <= stsg_pkg::CONTAINER_BYTES_RST;
      cfg_q.big_endian_order  <= 1'b0;
      cfg_q.unsigned_format   <= 1'b0;
      acc_q                   <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
      acc_q <= acc_d;
    end
  end

endmodule

@@ src/stsg_queue.sv @@
// Short register queue of resolved frames between the front and back ends.
// Depends on stsg_pkg and stsg_stream_if.
module stsg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stsg_stream_if.sink   in_i,
  stsg_stream_if.source out_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stsg_pkg::frame_t  entries_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign in_i.ready  = (count_q != CNT_W'(DEPTH));
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = entries_q[rptr_q];
  assign push        = in_i.valid & in_i.ready;
  assign pop         = out_o.valid & out_o.ready;

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= in_i.data;
    end
  end

endmodule

@@ src/stsg_back.sv @@
// Back end: sine table load, table read, scaling, formatting and per-channel output register.
// Depends on stsg_pkg, stsg_stream_if and stsg_ram.
module stsg_back #(
  parameter int unsigned CHANNELS        = 1,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  stsg_stream_if.sink    frame_i,
  stsg_stream_if.source  sample_o,
  input  stsg_pkg::cfg_t cfg_i,
  output logic           fill_done_o
);

  localparam int unsigned AW    = TABLE_ADDR_BITS;
  localparam int unsigned DEPTH = (2 ** AW) + 1;
  localparam int unsigned RAW   = $clog2(DEPTH);
  localparam int unsigned MW    = stsg_pkg::MAG_W;
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [RAW-1:0] FULL_SPAN = RAW'(2 ** AW);

  function automatic logic [DEPTH*MW-1:0] build_image();
    logic [DEPTH*MW-1:0] img;
    img = '0;
    for (int unsigned n = 0; n < DEPTH; n++) begin
      img[n*MW +: MW] = stsg_pkg::sine_entry(n, AW);
    end
    return img;
  endfunction

  localparam logic [DEPTH*MW-1:0] ROM_IMAGE = build_image();

  function automatic logic [30:0] max_level(logic [1:0] code);
    case (code)
      stsg_pkg::SW_8BIT:  return 31'h0000007F;
      stsg_pkg::SW_16BIT: return 31'h00007FFF;
      stsg_pkg::SW_24BIT: return 31'h007FFFFF;
      default:            return 31'h7FFFFFFF;
    endcase
  endfunction

  function automatic logic [31:0] top_bit(logic [1:0] code);
    case (code)
      stsg_pkg::SW_8BIT:  return 32'h00000080;
      stsg_pkg::SW_16BIT: return 32'h00008000;
      stsg_pkg::SW_24BIT: return 32'h00800000;
      default:            return 32'h80000000;
    endcase
  endfunction

  // Table load sweep
  logic [RAW-1:0] fill_q;
  logic           fill_done_q;

  // Stage 1: table read in flight
  logic           v1_q;
  logic [1:0]     quad1_q;
  logic           eob1_q;
  logic [MW-1:0]  mag;

  // Stage 2: scaled magnitude
  logic           v2_q;
  logic           neg2_q;
  logic           eob2_q;
  logic [30:0]    scaled2_q;

  // Output register
  logic           out_v_q;
  logic [31:0]    word_q;
  logic [CW-1:0]  ch_q;
  logic           eob3_q;

  logic           en1, en2, en3, pop, last;
  logic [1:0]     quad;
  logic [AW-1:0]  idx;
  logic [RAW-1:0] raddr;
  logic [53:0]    prod;
  logic [31:0]    res;
  logic [2:0]     cont, nbytes, nb, src;
  logic [31:0]    word;

  assign fill_done_o = fill_done_q;

  // Load the quarter-wave table, one entry a cycle, after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      fill_done_q <= 1'b0;
    end else if (!fill_done_q) begin
      if (fill_q == RAW'(DEPTH - 1)) begin
        fill_done_q <= 1'b1;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Fold the phase into a quarter-wave address
  assign quad  = frame_i.data.phase[31:30];
  assign idx   = frame_i.data.phase[29 -: AW];
  assign raddr = quad[0] ? (FULL_SPAN - {1'b0, idx}) : {1'b0, idx};

  stsg_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (!fill_done_q),
    .waddr_i (fill_q),
    .wdata_i (ROM_IMAGE[32'(fill_q) * MW +: MW]),
    .re_i    (pop),
    .raddr_i (raddr),
    .rdata_o (mag)
  );

  // Stall chain from the output side back to the queue
  assign last  = (ch_q == CW'(CHANNELS - 1));
  assign en3   = !out_v_q || (sample_o.ready && last);
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign frame_i.ready = en1 & fill_done_q;
  assign pop   = frame_i.valid & frame_i.ready;

  assign prod = 54'(mag) * 54'(max_level(cfg_i.sample_width_code));

  // Sign, offset binary and byte packing
  always_comb begin
    res = neg2_q ? (32'd0 - {1'b0, scaled2_q}) : {1'b0, scaled2_q};
    if (cfg_i.unsigned_format) begin
      res = res ^ top_bit(cfg_i.sample_width_code);
    end
    if (cfg_i.container_bytes == 3'd0) begin
      cont = 3'd1;
    end else if (cfg_i.container_bytes > 3'd4) begin
      cont = 3'd4;
    end else begin
      cont = cfg_i.container_bytes;
    end
    nbytes = {1'b0, cfg_i.sample_width_code} + 3'd1;
    nb     = (nbytes > cont) ? cont : nbytes;
    word   = 32'd0;
    src    = 3'd0;
    for (int p = 0; p < 4; p++) begin
      src = cfg_i.big_endian_order ? (cont - 3'd1 - 3'(p)) : 3'(p);
      if ((3'(p) < cont) && (src < nb)) begin
        word[8*p +: 8] = res[{src[1:0], 3'b000} +: 8];
      end
    end
  end

  // Advance the pipeline valid bits and repeat each frame per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
      ch_q    <= '0;
    end else begin
      if (en1) begin
        v1_q <= pop;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        out_v_q <= v2_q;
        ch_q    <= '0;
      end else if (out_v_q && sample_o.ready) begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      quad1_q <= quad;
      eob1_q  <= frame_i.data.end_of_burst;
    end
    if (en2 && v1_q) begin
      neg2_q    <= quad1_q[1];
      eob2_q    <= eob1_q;
      scaled2_q <= prod[53:23];
    end
    if (en3 && v2_q) begin
      word_q <= word;
      eob3_q <= eob2_q;
    end
  end

  assign sample_o.valid              = out_v_q;
  assign sample_o.data.sample_bytes  = word_q;
  assign sample_o.data.channel_index = 3'(ch_q);
  assign sample_o.data.last_of_frame = last;
  assign sample_o.data.burst_done    = last & eob3_q;

`ifndef SYNTHESIS
  a_ch_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (32'(ch_q) < CHANNELS))
    else $error("channel slot beyond channel count");

  a_ch_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && sample_o.ready && !last) |=> (out_v_q && (ch_q == CW'($past(ch_q) + 1'b1))))
    else $error("channel copy lost or not advanced");

  a_fill_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done_q |=> (fill_done_q && (fill_q == RAW'(DEPTH - 1))))
    else $error("table load restarted");

  a_stage2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en2) |=> (v2_q && $stable(scaled2_q) && $stable(neg2_q)))
    else $error("stalled scaled sample changed");
`endif

endmodule

@@ test/stsg_sample_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the sine tone sample generator: follows register writes and frame requests,
// predicts every sample and compares it with what leaves the block. Depends on stsg_pkg.
module stsg_sample_checker #(
  parameter int unsigned CHANNELS        = 1,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  stsg_pkg::cfg_wr_t    cfg_wr_i,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  stsg_pkg::frame_req_t req_i,
  input  logic                 smp_valid_i,
  input  logic                 smp_ready_i,
  input  stsg_pkg::sample_t    smp_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  localparam int unsigned STEPS = 1 << TABLE_ADDR_BITS;

  logic [22:0]       quarter_sine [0:STEPS];
  stsg_pkg::cfg_t    active_cfg;
  logic [31:0]       tone_phase;
  stsg_pkg::sample_t expected_samples [$];
  int unsigned       mismatches;
  stsg_pkg::sample_t got;
  stsg_pkg::sample_t want;
  logic [31:0]       word;

  // Sine of n quarter-table steps in Q0.23, via a fixed-point Taylor polynomial
  function automatic logic [22:0] sine_magnitude(int unsigned n);
    logic [63:0] arg;
    logic [63:0] sq;
    logic [63:0] poly;
    logic [63:0] div;
    logic [63:0] s;
    int unsigned k;
    arg  = ((64'(n) << (30 - TABLE_ADDR_BITS)) * stsg_pkg::HALF_PI_Q30) >> 30;
    sq   = (arg * arg) >> 30;
    poly = stsg_pkg::Q30_ONE;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: div = 64'd156;
        1: div = 64'd110;
        2: div = 64'd72;
        3: div = 64'd42;
        4: div = 64'd20;
        default: div = 64'd6;
      endcase
      poly = stsg_pkg::Q30_ONE - ((sq * poly) >> 30) / div;
    end
    s = (((arg * poly) >> 30) + 64'd64) >> 7;
    if (s > 64'h7FFFFF) begin
      s = 64'h7FFFFF;
    end
    return s[22:0];
  endfunction

  // Memory-order container for one phase under the current settings
  function automatic logic [31:0] expected_container(logic [31:0] phase);
    logic [1:0]  quadrant;
    int unsigned index;
    int unsigned nbits;
    logic [63:0] scaled;
    logic [31:0] level;
    int unsigned slots;
    int unsigned fill;
    int unsigned k;
    int unsigned slot;
    logic [31:0] packed_word;
    quadrant = phase[31:30];
    index    = (phase >> (30 - TABLE_ADDR_BITS)) & (STEPS - 1);
    if (quadrant[0]) begin
      index = STEPS - index;
    end
    nbits  = 8 * (int'(active_cfg.sample_width_code) + 1);
    scaled = (64'(quarter_sine[index]) * ((64'd1 << (nbits - 1)) - 64'd1)) >> 23;
    level  = scaled[31:0];
    if (quadrant[1]) begin
      level = 32'd0 - level;
    end
    if (active_cfg.unsigned_format) begin
      level = level ^ (32'd1 << (nbits - 1));
    end
    // Clamp the container to 1..4 bytes; narrow containers drop the top bytes
    slots = active_cfg.container_bytes;
    if (slots < 1) begin
      slots = 1;
    end
    if (slots > 4) begin
      slots = 4;
    end
    fill = (nbits / 8 < slots) ? nbits / 8 : slots;
    packed_word = '0;
    for (k = 0; k < fill; k++) begin
      slot = active_cfg.big_endian_order ? slots - 1 - k : k;
      packed_word = packed_word | (((level >> (8 * k)) & 32'hFF) << (8 * slot));
    end
    return packed_word;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    int unsigned n;
    for (n = 0; n <= STEPS; n++) begin
      quarter_sine[n] = sine_magnitude(n);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cfg = '{tuning_word: stsg_pkg::TUNING_WORD_RST,
                     sample_width_code: stsg_pkg::SAMPLE_WIDTH_RST,
                     container_bytes: stsg_pkg::CONTAINER_BYTES_RST, big_endian_order: 1'b0,
                     unsigned_format: 1'b0};
      tone_phase = '0;
      mismatches = 0;
      expected_samples.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Check an outgoing sample against the oldest prediction
      if (smp_valid_i && smp_ready_i) begin
        got = smp_i;
        if (expected_samples.size() == 0) begin
          $error("sample_bytes: expected none, actual %0h", got.sample_bytes);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          compare_field("sample_bytes", want.sample_bytes, got.sample_bytes);
          compare_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
          compare_field("last_of_frame", 32'(want.last_of_frame), 32'(got.last_of_frame));
          compare_field("burst_done", 32'(want.burst_done), 32'(got.burst_done));
        end
      end

      // Track register writes, masked to each register's width
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_wr_i.reg_index)
          stsg_pkg::REG_TUNING_WORD:     active_cfg.tuning_word       = cfg_wr_i.wdata;
          stsg_pkg::REG_SAMPLE_WIDTH:    active_cfg.sample_width_code = cfg_wr_i.wdata[1:0];
          stsg_pkg::REG_CONTAINER_BYTES: active_cfg.container_bytes   = cfg_wr_i.wdata[2:0];
          stsg_pkg::REG_BIG_ENDIAN:      active_cfg.big_endian_order  = cfg_wr_i.wdata[0];
          stsg_pkg::REG_UNSIGNED_FORMAT: active_cfg.unsigned_format   = cfg_wr_i.wdata[0];
          default: ;
        endcase
      end

      // Predict one sample per channel, then advance the phase
      if (req_valid_i && req_ready_i) begin
        if (req_i.phase_restart) begin
          tone_phase = '0;
        end
        word = expected_container(tone_phase);
        for (int unsigned c = 0; c < CHANNELS; c++) begin
          expected_samples.push_back('{sample_bytes: word, channel_index: 3'(c),
                                       last_of_frame: (c == CHANNELS - 1),
                                       burst_done: (c == CHANNELS - 1) && req_i.end_of_burst});
        end
        tone_phase = tone_phase + active_cfg.tuning_word;
      end

      errors_o  <= mismatches;
      pending_o <= expected_samples.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the sine tone sample generator: clock, reset, register writes, frame
// requests and output back-pressure. Depends on stsg_pkg, stsg_stream_if, stsg_sample_checker.
module tb_top;

  localparam int unsigned CHANNELS         = 1;
  localparam int unsigned TABLE_ADDR_BITS  = 10;
  localparam int unsigned CLK_PERIOD       = 20;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned RANDOM_PHASES    = 10;
  localparam int unsigned FRAMES_PER_PHASE = 41;
  localparam int unsigned IDLE_LIMIT       = 2 * (1 << TABLE_ADDR_BITS) + 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_off_req = 1'b0;
  logic        any_accept;

  stsg_stream_if #(.payload_t(stsg_pkg::cfg_wr_t))    cfg_if ();
  stsg_stream_if #(.payload_t(stsg_pkg::frame_req_t)) req_if ();
  stsg_stream_if #(.payload_t(stsg_pkg::sample_t))    smp_if ();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sine_tone_sample_generator #(
    .CHANNELS       (CHANNELS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_if),
    .frame_req_i(req_if),
    .sample_o   (smp_if)
  );

  stsg_sample_checker #(
    .CHANNELS       (CHANNELS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) checker_inst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_if.valid),
    .cfg_ready_i(cfg_if.ready),
    .cfg_wr_i   (cfg_if.data),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_i      (req_if.data),
    .smp_valid_i(smp_if.valid),
    .smp_ready_i(smp_if.ready),
    .smp_i      (smp_if.data),
    .errors_o   (mismatches),
    .pending_o  (outstanding)
  );

  // Fill unused upper bits of a register write with noise
  function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned bits);
    return ($urandom() << bits) | value;
  endfunction

  // Hold a register write until the block takes it; returns at a falling edge
  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: index, wdata: value};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // Wait until every predicted sample has left, then let the block settle
  task automatic settle();
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_settings(stsg_pkg::cfg_t c, bit stray);
    settle();
    if (stray) begin
      write_reg(3'(stsg_pkg::REG_UNSIGNED_FORMAT + $urandom_range(1, 3)), $urandom());
    end
    write_reg(stsg_pkg::REG_TUNING_WORD, c.tuning_word);
    write_reg(stsg_pkg::REG_SAMPLE_WIDTH, with_junk(32'(c.sample_width_code), 2));
    write_reg(stsg_pkg::REG_CONTAINER_BYTES, with_junk(32'(c.container_bytes), 3));
    write_reg(stsg_pkg::REG_BIG_ENDIAN, with_junk(32'(c.big_endian_order), 1));
    write_reg(stsg_pkg::REG_UNSIGNED_FORMAT, with_junk(32'(c.unsigned_format), 1));
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one frame request after a gap; returns at a falling edge with valid still high
  task automatic send_frame(bit restart, bit eob, int unsigned gap);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{phase_restart: restart, end_of_burst: eob};
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    stsg_pkg::cfg_t c;
    int unsigned    phase;
    int unsigned    n;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no writes
    send_frame(1'b1, 1'b0, 0);
    send_frame(1'b0, 1'b0, 3);
    send_frame(1'b0, 1'b1, 0);
    send_frame(1'b0, 1'b0, 12);
    req_if.valid <= 1'b0;

    // Quarter-turn steps hit every quadrant edge at full 32-bit width
    apply_settings('{tuning_word: 32'h4000_0000, sample_width_code: stsg_pkg::SW_32BIT,
                     container_bytes: 3'd4, big_endian_order: 1'b0,
                     unsigned_format: 1'b0}, 1'b0);
    send_frame(1'b1, 1'b0, 0);
    for (n = 0; n < 4; n++) begin
      send_frame(1'b0, n == 3, 0);
    end
    req_if.valid <= 1'b0;

    // 8-bit offset binary, zero-byte container acts as one byte
    apply_settings('{tuning_word: 32'h2000_0000, sample_width_code: stsg_pkg::SW_8BIT,
                     container_bytes: 3'd0, big_endian_order: 1'b1,
                     unsigned_format: 1'b1}, 1'b0);
    send_frame(1'b1, 1'b0, 1);
    send_frame(1'b0, 1'b0, 0);
    send_frame(1'b0, 1'b0, 2);
    send_frame(1'b0, 1'b1, 0);
    req_if.valid <= 1'b0;

    // Backward wrap from zero, oversize container acts as four bytes
    apply_settings('{tuning_word: 32'hFFFF_FFFF, sample_width_code: stsg_pkg::SW_16BIT,
                     container_bytes: 3'd7, big_endian_order: 1'b1,
                     unsigned_format: 1'b0}, 1'b0);
    send_frame(1'b1, 1'b0, 0);
    send_frame(1'b0, 1'b0, 0);
    send_frame(1'b0, 1'b1, 0);
    send_frame(1'b1, 1'b1, 5);
    req_if.valid <= 1'b0;

    // Container narrower than the sample drops its top bytes
    apply_settings('{tuning_word: 32'h0040_0000, sample_width_code: stsg_pkg::SW_32BIT,
                     container_bytes: 3'd2, big_endian_order: 1'b1,
                     unsigned_format: 1'b1}, 1'b0);
    send_frame(1'b1, 1'b0, 0);
    send_frame(1'b0, 1'b0, 0);
    send_frame(1'b0, 1'b0, 0);
    send_frame(1'b0, 1'b1, 0);
    req_if.valid <= 1'b0;

    // Frozen phase, 24-bit sample in three bytes
    apply_settings('{tuning_word: 32'h0, sample_width_code: stsg_pkg::SW_24BIT,
                     container_bytes: 3'd3, big_endian_order: 1'b0,
                     unsigned_format: 1'b1}, 1'b0);
    send_frame(1'b0, 1'b0, 0);
    send_frame(1'b1, 1'b0, 0);
    send_frame(1'b0, 1'b1, 0);
    req_if.valid <= 1'b0;

    // Random settings and bursts
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: c.tuning_word = $urandom();
        1: c.tuning_word = $urandom_range(1, 32'h0010_0000);
        2: c.tuning_word = {2'($urandom_range(0, 3)), 30'd0};
        default: c.tuning_word = 32'd0 - $urandom_range(0, 4096);
      endcase
      c.sample_width_code = 2'($urandom_range(0, 3));
      c.container_bytes   = 3'($urandom_range(0, 7));
      c.big_endian_order  = 1'($urandom_range(0, 1));
      c.unsigned_format   = 1'($urandom_range(0, 1));
      apply_settings(c, 1'b1);
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 4) != 2;
      if (phase == 3) begin
        // Flood requests while the output stalls for a long stretch
        tx_idle      = 1'b0;
        hold_off_req = 1'b1;
      end
      for (n = 0; n < FRAMES_PER_PHASE; n++) begin
        send_frame($urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0,
                   tx_idle ? $urandom_range(0, 12) : 0);
      end
      req_if.valid <= 1'b0;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output back-pressure: random pauses per sample, one long hold on request
  initial begin
    int unsigned pause;
    bit          held;
    held         = 1'b0;
    smp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !held) begin
        smp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end else begin
        pause = rx_idle ? $urandom_range(0, 12) : 0;
        if (pause != 0) begin
          smp_if.ready <= 1'b0;
          repeat (pause) @(negedge clk_i);
        end
      end
      smp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!smp_if.valid);
      @(negedge clk_i);
    end
  end

  // Watchdog: end the run when no channel moves for too long
  assign any_accept = (cfg_if.valid && cfg_if.ready) || (req_if.valid && req_if.ready) ||
                      (smp_if.valid && smp_if.ready);

  always @(posedge clk_i) begin
    if (!rst_ni || any_accept) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
